// File: hdl/range_prime_counter_assert.svh
// ----------------------------------------------------------------------------
// range_prime_counter assertion macros
// Concurrent assertion helpers clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RANGE_PRIME_COUNTER_ASSERT_SVH
`define RANGE_PRIME_COUNTER_ASSERT_SVH

// same-cycle implication
`define RPC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("range_prime_counter: assertion failed");

// next-cycle implication
`define RPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("range_prime_counter: assertion failed");

`endif

// File: hdl/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types and constants of the range prime counter.
// ----------------------------------------------------------------------------
package rpc_pkg;

    localparam int LIMIT_RESET = 100000;
    localparam int SIZE_RESET  = 1000;
    localparam int FIRST_DIV   = 2;

    localparam logic REG_RANGE_LIMIT = 1'b0;
    localparam logic REG_TASK_SIZE   = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } div_status_t;

endpackage

// File: hdl/rpc_divider.sv
// ----------------------------------------------------------------------------
// rpc_divider
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rpc_divider #(
    parameter int VALUE_BITS = 17
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [VALUE_BITS-1:0]   dividend,
    input  logic [VALUE_BITS-1:0]   divisor,
    output rpc_pkg::div_status_t    status
);
    import rpc_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] dvs_reg, dvs_next;
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   diff;

    assign trial = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VALUE_BITS);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in next dividend bit, subtract when it fits
            quo_next = {quo_reg[VALUE_BITS-2:0], 1'b0};
            if (diff[VALUE_BITS])
                rem_next = trial[VALUE_BITS-1:0];
            else
                rem_next = diff[VALUE_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy     = busy_reg;
    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

endmodule

// File: hdl/range_prime_counter.sv
// ----------------------------------------------------------------------------
// range_prime_counter
// Counts the primes in a clamped task range by bit-serial trial division.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, range_start) takes one task start S.
//   The block examines S <= n < min(S + task_size, range_limit) and returns
//   one item on the output channel (out_valid/out_ready, prime_count).
//   Configuration: cfg_we writes cfg_data to register cfg_index (0 is
//   range_limit, 1 is task_size); write only while the block is idle.
// Operation:
//   One task at a time. Each trial division is a test in ST_TEST, a pass
//   through the serial remainder unit, which shifts in the dividend bit by
//   bit, and a read of the remainder in ST_DIV. A candidate below 2 or
//   found prime is settled in ST_TEST alone. Trial divisors run from 2 up
//   to sqrt(n); the range end check and the result register each add a step.
// Reset:
//   range_limit returns to 100000 and task_size to 1000; no item is pending.
// Stall:
//   The result sits in an output register; a new task is taken while it
//   waits, and a finished task holds until the output register is free.
// ----------------------------------------------------------------------------
module range_prime_counter #(
    parameter int VALUE_BITS = 17
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [VALUE_BITS-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] range_start,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_BITS-1:0] prime_count
);
    import rpc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_TEST   = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [VALUE_BITS-1:0] DIV_FIRST = VALUE_BITS'(FIRST_DIV);
    localparam logic [VALUE_BITS:0]   SQ_FIRST  = (VALUE_BITS + 1)'(FIRST_DIV * FIRST_DIV);

    logic [1:0]            state_reg, state_next;
    logic [VALUE_BITS-1:0] limit_reg, size_reg;
    logic [VALUE_BITS-1:0] candidate_reg, candidate_next;
    logic [VALUE_BITS-1:0] range_end_reg, range_end_next;
    logic [VALUE_BITS-1:0] trial_divisor_reg, trial_divisor_next;
    logic [VALUE_BITS:0]   square_reg, square_next;
    logic [VALUE_BITS-1:0] running_count_reg, running_count_next;
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] prime_count_reg, prime_count_next;
    logic [VALUE_BITS:0]   end_sum;
    logic                  div_start;
    div_status_t           div_status;

    assign end_sum  = {1'b0, range_start} + {1'b0, size_reg};
    assign in_ready = (state_reg == ST_IDLE);

    rpc_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (candidate_reg),
        .divisor  (trial_divisor_reg),
        .status   (div_status)
    );

    always_comb
    begin
        state_next         = state_reg;
        candidate_next     = candidate_reg;
        range_end_next     = range_end_reg;
        trial_divisor_next = trial_divisor_reg;
        square_next        = square_reg;
        running_count_next = running_count_reg;
        out_valid_next     = out_valid_reg;
        prime_count_next   = prime_count_reg;
        div_start          = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    candidate_next = range_start;
                    if (end_sum > {1'b0, limit_reg})
                        range_end_next = limit_reg;
                    else
                        range_end_next = end_sum[VALUE_BITS-1:0];
                    running_count_next = '0;
                    trial_divisor_next = DIV_FIRST;
                    square_next        = SQ_FIRST;
                    state_next         = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (candidate_reg >= range_end_reg)
                begin
                    candidate_next = range_end_reg;
                    state_next     = ST_FINISH;
                end
                else if (candidate_reg < DIV_FIRST)
                    candidate_next = candidate_reg + 1'b1;
                else if (square_reg > {1'b0, candidate_reg})
                begin
                    running_count_next = running_count_reg + 1'b1;
                    candidate_next     = candidate_reg + 1'b1;
                    trial_divisor_next = DIV_FIRST;
                    square_next        = SQ_FIRST;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    if (div_status.rem_zero)
                    begin
                        candidate_next     = candidate_reg + 1'b1;
                        trial_divisor_next = DIV_FIRST;
                        square_next        = SQ_FIRST;
                    end
                    else
                    begin
                        // advance (d+1)^2 = d^2 + 2d + 1
                        trial_divisor_next = trial_divisor_reg + 1'b1;
                        square_next = square_reg + {trial_divisor_reg, 1'b1};
                    end
                    state_next = ST_TEST;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    prime_count_next = running_count_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            limit_reg         <= VALUE_BITS'(LIMIT_RESET);
            size_reg          <= VALUE_BITS'(SIZE_RESET);
            candidate_reg     <= '0;
            range_end_reg     <= '0;
            trial_divisor_reg <= DIV_FIRST;
            square_reg        <= SQ_FIRST;
            running_count_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            candidate_reg     <= candidate_next;
            range_end_reg     <= range_end_next;
            trial_divisor_reg <= trial_divisor_next;
            square_reg        <= square_next;
            running_count_reg <= running_count_next;
            out_valid_reg     <= out_valid_next;
            if (cfg_we && cfg_index == REG_RANGE_LIMIT)
                limit_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_TASK_SIZE)
                size_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        prime_count_reg <= prime_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign prime_count = prime_count_reg;

    `include "range_prime_counter_assert.svh"

    `RPC_ASSERT_SAME(a_div_busy_in_div, div_status.busy, state_reg == ST_DIV)
    `RPC_ASSERT_NEXT(a_accept_to_test, in_valid && in_ready, state_reg == ST_TEST)
    `RPC_ASSERT_SAME(a_count_bounded, 1'b1, running_count_reg <= candidate_reg)
    `RPC_ASSERT_SAME(a_div_in_range, state_reg == ST_DIV, candidate_reg < range_end_reg)
    `RPC_ASSERT_SAME(a_divisor_min, 1'b1, trial_divisor_reg >= DIV_FIRST)

endmodule
